// ----- rtl/ahet_pkg.sv -----
// Shared types, constants and helpers for the angular hull enclosure tracker.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package ahet_pkg;

  localparam int DIR_DEPTH = 1024;
  localparam int IDX_W     = $clog2(DIR_DEPTH);
  localparam int CNT_W     = $clog2(DIR_DEPTH + 1);
  localparam int COORD_W   = 31;
  localparam int OFF_W     = 32;
  localparam int PROD_W    = 2 * OFF_W;
  localparam int MULT_W    = 16;
  localparam int HITS_W    = 20;
  localparam int OUT_W     = 11;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [OFF_W-1:0]   off_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [MULT_W-1:0]         mult_t;
  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [HITS_W-1:0]         hits_t;
  typedef logic [OUT_W-1:0]          out_cnt_t;

  localparam logic CFG_CENTER_X = 1'b0;
  localparam logic CFG_CENTER_Y = 1'b1;
  localparam logic REQ_ADD      = 1'b0;
  localparam logic REQ_REMOVE   = 1'b1;

  typedef struct packed {
    off_t  x;
    off_t  y;
    mult_t m;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INC,
    CMD_DEC,
    CMD_INSERT,
    CMD_REMOVE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    cnt_t     pos;
  } cell_cmd_t;

  typedef struct packed {
    logic ahead;
    logic same;
    logic neg;
    logic posc;
    logic pair_neg;
    logic mult_gt1;
  } cell_flags_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROD,
    S_FLAG,
    S_APPLY,
    S_WAIT,
    S_FIX,
    S_DONE
  } state_t;

  // 0 for the upper half-plane plus the positive x axis, 1 otherwise
  function automatic logic half_of(input off_t x, input off_t y);
    return !((y > 0) || ((y == 0) && (x > 0)));
  endfunction

  function automatic cnt_t sat_dec(input cnt_t v, input logic c);
    return (c && (v != '0)) ? cnt_t'(v - cnt_t'(1)) : v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ahet_in_if.sv -----
// Request channel: valid/ready handshake with add/remove and point payload.
// Depends on ahet_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ahet_in_if import ahet_pkg::*;;
  logic   valid;
  logic   ready;
  logic   req_type;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, output req_type, output point_x, output point_y,
                  input ready);
  modport sink   (input valid, input req_type, input point_x, input point_y,
                  output ready);
endinterface
`default_nettype wire

// ----- rtl/ahet_out_if.sv -----
// Result channel: valid/ready handshake with enclosure status and counts.
// Depends on ahet_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ahet_out_if import ahet_pkg::*;;
  logic     valid;
  logic     ready;
  logic     enclosed;
  out_cnt_t distinct_directions;
  out_cnt_t gap_count;
  logic     rejected;

  modport source (output valid, output enclosed, output distinct_directions,
                  output gap_count, output rejected, input ready);
  modport sink   (input valid, input enclosed, input distinct_directions,
                  input gap_count, input rejected, output ready);
endinterface
`default_nettype wire

// ----- rtl/ahet_cell.sv -----
// One table slot: holds a direction and its multiplicity, compares it with
// the current query and its successor. Depends on ahet_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ahet_cell import ahet_pkg::*; (
  input  logic        clk,
  input  cnt_t        idx,
  input  cnt_t        n,
  input  cell_cmd_t   cmd,
  input  off_t        d_x,
  input  off_t        d_y,
  input  entry_t      left_e,
  input  entry_t      right_e,
  input  off_t        succ_x,
  input  off_t        succ_y,
  output entry_t      ent,
  output cell_flags_t flags
);

  entry_t ent_r, ent_nxt;
  prod_t  p_r, q_r, pp_r, pq_r;
  logic   valid, he, hd;

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    p_r   <= ent_r.x * d_y;
    q_r   <= ent_r.y * d_x;
    pp_r  <= ent_r.x * succ_y;
    pq_r  <= ent_r.y * succ_x;
  end

  always_comb begin
    ent_nxt = ent_r;
    case (cmd.op)
      CMD_INC: begin
        if (idx == cmd.pos && ent_r.m != '1) ent_nxt.m = mult_t'(ent_r.m + mult_t'(1));
      end
      CMD_DEC: begin
        if (idx == cmd.pos) ent_nxt.m = mult_t'(ent_r.m - mult_t'(1));
      end
      CMD_INSERT: begin
        if (idx > cmd.pos) begin
          ent_nxt = left_e;
        end else if (idx == cmd.pos) begin
          ent_nxt.x = d_x;
          ent_nxt.y = d_y;
          ent_nxt.m = mult_t'(1);
        end
      end
      CMD_REMOVE: begin
        if (idx >= cmd.pos) ent_nxt = right_e;
      end
      default: ;
    endcase
  end

  assign valid = (idx < n);
  assign he    = half_of(ent_r.x, ent_r.y);
  assign hd    = half_of(d_x, d_y);

  always_comb begin
    flags.ahead    = valid && ((!he && hd) || ((he == hd) && (p_r > q_r)));
    flags.same     = valid && (he == hd) && (p_r == q_r);
    flags.neg      = p_r < q_r;
    flags.posc     = p_r > q_r;
    flags.pair_neg = pp_r < pq_r;
    flags.mult_gt1 = ent_r.m > mult_t'(1);
  end

  assign ent = ent_r;

endmodule
`default_nettype wire

// ----- rtl/ahet_chain.sv -----
// Row of ahet_cell slots with neighbor wiring and the insertion-point encoder.
// Depends on ahet_pkg and ahet_cell.
`timescale 1ns / 1ps
`default_nettype none
module ahet_chain import ahet_pkg::*; (
  input  logic                 clk,
  input  cnt_t                 n,
  input  cell_cmd_t            cmd,
  input  off_t                 d_x,
  input  off_t                 d_y,
  output logic [DIR_DEPTH-1:0] neg_v,
  output logic [DIR_DEPTH-1:0] posc_v,
  output logic [DIR_DEPTH-1:0] pair_v,
  output logic [DIR_DEPTH-1:0] mgt1_v,
  output cnt_t                 pos,
  output logic                 found
);

  entry_t                 ent [DIR_DEPTH];
  cell_flags_t            flg [DIR_DEPTH];
  logic [DIR_DEPTH-1:0]   ahead_v, same_v;
  logic [DIR_DEPTH:0]     bound_v;

  for (genvar i = 0; i < DIR_DEPTH; i++) begin : g_cell
    entry_t le, re, se;
    assign le = (i == 0) ? ent[0] : ent[(i == 0) ? 0 : i - 1];
    assign re = (i == DIR_DEPTH - 1) ? ent[i] : ent[(i == DIR_DEPTH - 1) ? i : i + 1];
    // wrap the last used slot back to the first
    assign se = ((i == DIR_DEPTH - 1) || (cnt_t'(i + 1) == n)) ? ent[0]
              : ent[(i == DIR_DEPTH - 1) ? 0 : i + 1];

    ahet_cell u_cell (
      .clk    (clk),
      .idx    (cnt_t'(i)),
      .n      (n),
      .cmd    (cmd),
      .d_x    (d_x),
      .d_y    (d_y),
      .left_e (le),
      .right_e(re),
      .succ_x (se.x),
      .succ_y (se.y),
      .ent    (ent[i]),
      .flags  (flg[i])
    );

    assign ahead_v[i]  = flg[i].ahead;
    assign same_v[i]   = flg[i].same;
    assign neg_v[i]    = flg[i].neg;
    assign posc_v[i]   = flg[i].posc;
    assign pair_v[i]   = flg[i].pair_neg;
    assign mgt1_v[i]   = flg[i].mult_gt1;
    assign bound_v[i]  = ((i == 0) ? 1'b1 : ahead_v[(i == 0) ? 0 : i - 1]) && !ahead_v[i];
  end

  assign bound_v[DIR_DEPTH] = ahead_v[DIR_DEPTH-1];

  // entries are sorted, so exactly one boundary bit is set
  always_comb begin
    pos = '0;
    for (int i = 0; i <= DIR_DEPTH; i++) begin
      if (bound_v[i]) pos = pos | cnt_t'(i);
    end
  end

  assign found = |same_v;

endmodule
`default_nettype wire

// ----- rtl/angular_hull_enclosure_tracker_core.sv -----
// Top level: request FSM, counters, configuration registers and result stage.
// Depends on ahet_pkg, ahet_in_if, ahet_out_if and ahet_chain.
//
//  channel   dir  handshake            content
//  in_chan   in   valid/ready          req_type, point_x, point_y
//  out_chan  out  valid/ready          enclosed, distinct_directions, gap_count, rejected
//  cfg_*     in   cfg_we, no stall     cfg_idx selects center_x / center_y
//
// One request at a time. A point equal to the center skips the table; other
// requests pass through cell products, boundary encode and shift, and a remove
// of the last copy on a ray with three or more directions stored adds one more
// product pass for the closing pair.
// Synchronous active-low reset clears counts; table contents need none.
// A waiting result holds the block in its final state until taken.
`timescale 1ns / 1ps
`default_nettype none
module angular_hull_enclosure_tracker_core import ahet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  ahet_in_if.sink    in_chan,
  ahet_out_if.source out_chan,
  input  logic       cfg_we,
  input  logic       cfg_idx,
  input  coord_t     cfg_wdata
);

  state_t    state_r, state_nxt;
  coord_t    cx_r, cy_r;
  off_t      dx_r, dy_r, dx_nxt, dy_nxt;
  logic      req_r;
  cnt_t      n_r, n_nxt, gap_r, gap_nxt, pos_r;
  hits_t     hits_r, hits_nxt;
  logic      found_r, rej_r, rej_nxt;
  logic      ov_r, enc_r, rjo_r;
  out_cnt_t  dd_r, gc_r;
  cell_cmd_t cmd;
  cnt_t      pos_c, pvo, nxo;
  logic      found_c, accept, center_pt, out_free;
  logic [DIR_DEPTH-1:0] neg_v, posc_v, pair_v, mgt1_v;

  assign accept    = in_chan.valid && in_chan.ready;
  assign center_pt = (dx_r == '0) && (dy_r == '0);
  assign out_free  = !ov_r || out_chan.ready;
  assign dx_nxt    = off_t'(in_chan.point_x) - off_t'(cx_r);
  assign dy_nxt    = off_t'(in_chan.point_y) - off_t'(cy_r);

  ahet_chain u_chain (
    .clk   (clk),
    .n     (n_r),
    .cmd   (cmd),
    .d_x   (dx_r),
    .d_y   (dy_r),
    .neg_v (neg_v),
    .posc_v(posc_v),
    .pair_v(pair_v),
    .mgt1_v(mgt1_v),
    .pos   (pos_c),
    .found (found_c)
  );

  assign pvo = (pos_r == '0) ? cnt_t'(n_r - cnt_t'(1)) : cnt_t'(pos_r - cnt_t'(1));
  assign nxo = (pos_r == n_r) ? '0 : pos_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_PROD;
      S_PROD:  state_nxt = center_pt ? S_DONE : S_FLAG;
      S_FLAG:  state_nxt = S_APPLY;
      S_APPLY: begin
        if (req_r == REQ_REMOVE && found_r && !mgt1_v[pos_r[IDX_W-1:0]] && n_r > cnt_t'(2))
          state_nxt = S_WAIT;
        else
          state_nxt = S_DONE;
      end
      S_WAIT:  state_nxt = S_FIX;
      S_FIX:   state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath updates
  always_comb begin
    in_chan.ready = (state_r == S_IDLE);
    cmd.op        = CMD_HOLD;
    cmd.pos       = pos_r;
    n_nxt         = n_r;
    gap_nxt       = gap_r;
    hits_nxt      = hits_r;
    rej_nxt       = rej_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) rej_nxt = 1'b0;
      end
      S_PROD: begin
        if (center_pt) begin
          if (req_r == REQ_ADD) begin
            if (hits_r != '1) hits_nxt = hits_t'(hits_r + hits_t'(1));
          end else if (hits_r != '0) begin
            hits_nxt = hits_t'(hits_r - hits_t'(1));
          end else begin
            rej_nxt = 1'b1;
          end
        end
      end
      S_APPLY: begin
        if (req_r == REQ_ADD) begin
          if (found_r) begin
            cmd.op = CMD_INC;
          end else if (n_r == cnt_t'(DIR_DEPTH)) begin
            rej_nxt = 1'b1;
          end else begin
            cmd.op  = CMD_INSERT;
            n_nxt   = cnt_t'(n_r + cnt_t'(1));
            gap_nxt = cnt_t'(sat_dec(gap_r, (n_r >= cnt_t'(2)) && pair_v[pvo[IDX_W-1:0]])
                    + cnt_t'((n_r != '0) && neg_v[pvo[IDX_W-1:0]])
                    + cnt_t'((n_r != '0) && posc_v[nxo[IDX_W-1:0]]));
          end
        end else if (!found_r) begin
          rej_nxt = 1'b1;
        end else if (mgt1_v[pos_r[IDX_W-1:0]]) begin
          cmd.op = CMD_DEC;
        end else begin
          cmd.op  = CMD_REMOVE;
          n_nxt   = cnt_t'(n_r - cnt_t'(1));
          gap_nxt = sat_dec(sat_dec(gap_r, (n_r > cnt_t'(1)) && pair_v[pvo[IDX_W-1:0]]),
                            (n_r > cnt_t'(1)) && pair_v[pos_r[IDX_W-1:0]]);
        end
      end
      S_FIX: begin
        // closing pair of the two former neighbors, now adjacent
        gap_nxt = cnt_t'(gap_r + cnt_t'(pair_v[pvo[IDX_W-1:0]]));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cx_r    <= '0;
      cy_r    <= '0;
      n_r     <= '0;
      gap_r   <= '0;
      hits_r  <= '0;
      rej_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      gap_r   <= gap_nxt;
      hits_r  <= hits_nxt;
      rej_r   <= rej_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CENTER_X: cx_r <= cfg_wdata;
          CFG_CENTER_Y: cy_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) ov_r <= 1'b1;
      else if (out_chan.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      req_r <= in_chan.req_type;
    end
    if (state_r == S_FLAG) begin
      pos_r   <= pos_c;
      found_r <= found_c;
    end
    if (state_r == S_DONE && out_free) begin
      enc_r <= (hits_r != '0) || ((n_r >= cnt_t'(2)) && (gap_r == '0));
      dd_r  <= out_cnt_t'(n_r);
      gc_r  <= out_cnt_t'(gap_r);
      rjo_r <= rej_r;
    end
  end

  assign out_chan.valid               = ov_r;
  assign out_chan.enclosed            = enc_r;
  assign out_chan.distinct_directions = dd_r;
  assign out_chan.gap_count           = gc_r;
  assign out_chan.rejected            = rjo_r;

endmodule
`default_nettype wire

// ----- rtl/ahet_chk.sv -----
// Port-level checks for the tracker core, attached by bind.
// Depends on ahet_pkg and the core's channel interfaces.
`timescale 1ns / 1ps
`default_nettype none
module ahet_chk import ahet_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input logic     enclosed,
  input out_cnt_t distinct_directions,
  input out_cnt_t gap_count
);

  // one transaction in flight: intake closes right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("intake stayed open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(gap_count)
                                && $stable(distinct_directions))
    else $error("result changed while stalled");

  // a taken result drops, or is replaced by a fresh one as intake reopens
  a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> !out_valid || in_ready) else $error("result repeated");

  a_gap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> gap_count <= distinct_directions) else $error("gap count too large");

  a_enclosed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && distinct_directions >= out_cnt_t'(2) && gap_count == '0 |-> enclosed)
    else $error("enclosure flag missing");

endmodule

bind angular_hull_enclosure_tracker_core ahet_chk u_ahet_chk (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .enclosed           (out_chan.enclosed),
  .distinct_directions(out_chan.distinct_directions),
  .gap_count          (out_chan.gap_count)
);
`default_nettype wire

// ----- tb/angular_hull_enclosure_tracker_core_tb.sv -----
// Self-checking testbench for angular_hull_enclosure_tracker_core: directed table
// followed by randomized add/remove traffic.
// Depends on ahet_pkg, ahet_in_if, ahet_out_if and the core RTL.
`timescale 1ns / 1ps
module angular_hull_enclosure_tracker_core_tb;
  import ahet_pkg::*;

  typedef struct {
    logic     enclosed;
    out_cnt_t dirs;
    out_cnt_t gaps;
    logic     rejected;
  } hull_status_t;

  typedef struct {
    logic         req;
    longint       x;
    longint       y;
    bit           typed;
    hull_status_t want;
  } stim_row_t;

  localparam longint CMIN = -(64'sd1 <<< 30);
  localparam longint CMAX = (64'sd1 <<< 30) - 1;
  localparam int     LIMIT = 5_000_000;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   cfg_we = 1'b0;
  logic   cfg_idx = CFG_CENTER_X;
  coord_t cfg_wdata = '0;

  ahet_in_if  in_if();
  ahet_out_if out_if();

  angular_hull_enclosure_tracker_core dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_if), .out_chan(out_if),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the direction table
  longint       ctr_x, ctr_y;
  longint       ray_x[DIR_DEPTH];
  longint       ray_y[DIR_DEPTH];
  int unsigned  ray_mult[DIR_DEPTH];
  int unsigned  ray_cnt, gap_cnt, hit_cnt;
  hull_status_t pending_status[$];
  int           errors = 0;
  bit           calm = 1'b0;
  bit           hold_off = 1'b0;

  function automatic int cross_sgn(longint ax, longint ay, longint bx, longint by);
    longint p, q;
    p = ax * by;
    q = ay * bx;
    return (p > q) ? 1 : ((p < q) ? -1 : 0);
  endfunction

  function automatic int lower_half(longint x, longint y);
    return (y > 0 || (y == 0 && x > 0)) ? 0 : 1;
  endfunction

  function automatic int angle_order(longint ax, longint ay, longint bx, longint by);
    int ha, hb, c;
    ha = lower_half(ax, ay);
    hb = lower_half(bx, by);
    if (ha != hb) return (ha < hb) ? -1 : 1;
    c = cross_sgn(ax, ay, bx, by);
    return (c > 0) ? -1 : ((c < 0) ? 1 : 0);
  endfunction

  function automatic bit wide_gap(int unsigned i, int unsigned j);
    return cross_sgn(ray_x[i], ray_y[i], ray_x[j], ray_y[j]) < 0;
  endfunction

  function automatic void gap_adj(bit up, bit c);
    if (c && up) gap_cnt++;
    else if (c && gap_cnt > 0) gap_cnt--;
  endfunction

  function automatic hull_status_t update_hull(logic req, coord_t px, coord_t py);
    hull_status_t r;
    longint dx, dy;
    int unsigned n, pos, pv, nx, m;
    bit found;
    int c;
    dx = longint'(px) - ctr_x;
    dy = longint'(py) - ctr_y;
    n = ray_cnt;
    pos = 0;
    found = 0;
    r.rejected = 1'b0;
    if (dx == 0 && dy == 0) begin
      if (req == REQ_ADD) begin
        if (hit_cnt < (1 << HITS_W) - 1) hit_cnt++;
      end else if (hit_cnt > 0) begin
        hit_cnt--;
      end else begin
        r.rejected = 1'b1;
      end
    end else begin
      while (pos < n) begin
        c = angle_order(ray_x[pos], ray_y[pos], dx, dy);
        if (c == 0) begin
          found = 1;
          break;
        end
        if (c > 0) break;
        pos++;
      end
      if (req == REQ_ADD) begin
        if (found) begin
          if (ray_mult[pos] < 65535) ray_mult[pos]++;
        end else if (n >= DIR_DEPTH) begin
          r.rejected = 1'b1;
        end else begin
          for (int unsigned k = n; k > pos; k--) begin
            ray_x[k] = ray_x[k-1];
            ray_y[k] = ray_y[k-1];
            ray_mult[k] = ray_mult[k-1];
          end
          ray_x[pos] = dx;
          ray_y[pos] = dy;
          ray_mult[pos] = 1;
          m = n + 1;
          ray_cnt = m;
          pv = (pos + m - 1) % m;
          nx = (pos + 1) % m;
          if (m > 2) gap_adj(0, wide_gap(pv, nx));
          if (m > 1) begin
            gap_adj(1, wide_gap(pv, pos));
            gap_adj(1, wide_gap(pos, nx));
          end
        end
      end else begin
        if (!found) begin
          r.rejected = 1'b1;
        end else if (ray_mult[pos] > 1) begin
          ray_mult[pos]--;
        end else begin
          pv = (pos + n - 1) % n;
          nx = (pos + 1) % n;
          if (n > 1) begin
            gap_adj(0, wide_gap(pv, pos));
            gap_adj(0, wide_gap(pos, nx));
          end
          if (n > 2) gap_adj(1, wide_gap(pv, nx));
          for (int unsigned k = pos; k + 1 < n; k++) begin
            ray_x[k] = ray_x[k+1];
            ray_y[k] = ray_y[k+1];
            ray_mult[k] = ray_mult[k+1];
          end
          ray_cnt = n - 1;
        end
      end
    end
    r.enclosed = (hit_cnt > 0) || (ray_cnt >= 2 && gap_cnt == 0);
    r.dirs = out_cnt_t'(ray_cnt);
    r.gaps = out_cnt_t'(gap_cnt);
    return r;
  endfunction

  function automatic bit roll_idle();
    return !calm && ($urandom_range(99) < 12);
  endfunction

  task automatic send_request(logic req, longint x, longint y, bit typed, hull_status_t want);
    hull_status_t r;
    in_if.valid    <= 1'b1;
    in_if.req_type <= req;
    in_if.point_x  <= coord_t'(x);
    in_if.point_y  <= coord_t'(y);
    do @(posedge clk); while (!in_if.ready);
    r = update_hull(req, coord_t'(x), coord_t'(y));
    pending_status.push_back(typed ? want : r);
    if (roll_idle()) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_plain(logic req, longint x, longint y);
    hull_status_t none;
    none = '{1'b0, '0, '0, 1'b0};
    send_request(req, x, y, 1'b0, none);
  endtask

  task automatic write_center(longint cx, longint cy);
    in_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending_status.size() == 0);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_CENTER_X;
    cfg_wdata <= coord_t'(cx);
    @(posedge clk);
    cfg_idx   <= CFG_CENTER_Y;
    cfg_wdata <= coord_t'(cy);
    @(posedge clk);
    cfg_we <= 1'b0;
    ctr_x = longint'(coord_t'(cx));
    ctr_y = longint'(coord_t'(cy));
  endtask

  // mostly small offsets around the center so rays repeat and removes hit
  task automatic random_traffic(int count);
    longint dx, dy;
    int k, sel;
    logic req;
    for (int i = 0; i < count; i++) begin
      calm = (i >= count / 2) && (i < count / 2 + 80);
      if (i == count / 4) hold_off = 1'b1;
      sel = $urandom_range(99);
      req = ($urandom_range(99) < 40) ? REQ_REMOVE : REQ_ADD;
      k = $urandom_range(1, 3);
      dx = (longint'($urandom_range(0, 8)) - 4) * k;
      dy = (longint'($urandom_range(0, 8)) - 4) * k;
      if (sel < 8) begin
        send_plain(req, longint'(coord_t'($urandom)), longint'(coord_t'($urandom)));
      end else begin
        send_plain(req, ctr_x + dx, ctr_y + dy);
      end
    end
    calm = 1'b0;
  endtask

  // directed table: typed expectations only where trivially known
  stim_row_t rows[] = '{
    '{REQ_REMOVE, 0, 0, 1, '{1'b0, 11'd0, 11'd0, 1'b1}},
    '{REQ_REMOVE, 5, 5, 1, '{1'b0, 11'd0, 11'd0, 1'b1}},
    '{REQ_ADD,    0, 0, 1, '{1'b1, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, 0, 0, 1, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    CMAX, 0, 1, '{1'b0, 11'd1, 11'd0, 1'b0}},
    '{REQ_ADD,    CMIN, 0, 1, '{1'b1, 11'd2, 11'd0, 1'b0}},
    '{REQ_ADD,    7, 0, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, 3, 0, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, 1, 0, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    0, CMAX, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    0, CMIN, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    CMAX, CMAX, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    CMIN, CMIN, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    CMIN, CMAX, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, -2, 2, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, CMIN, 0, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, 0, -9, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_REMOVE, 0, 4, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    -1, -1, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    0, 0, 0, '{1'b0, 11'd0, 11'd0, 1'b0}},
    '{REQ_ADD,    1, -1, 0, '{1'b0, 11'd0, 11'd0, 1'b0}}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = REQ_ADD;
    in_if.point_x = '0;
    in_if.point_y = '0;
    ctr_x = 0;
    ctr_y = 0;
    ray_cnt = 0;
    gap_cnt = 0;
    hit_cnt = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_center(0, 0);
    foreach (rows[i]) send_request(rows[i].req, rows[i].x, rows[i].y, rows[i].typed, rows[i].want);

    write_center($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
    random_traffic(350);
    write_center(CMIN, CMAX);
    random_traffic(350);
    in_if.valid <= 1'b0;

    wait (pending_status.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("angular_hull_enclosure_tracker_core: match");
    end else begin
      $display("angular_hull_enclosure_tracker_core: mismatch");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off
  initial begin
    int held;
    out_if.ready = 1'b0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && held < 400) begin
        held++;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !roll_idle();
      end
    end
  end

  always @(posedge clk) begin
    hull_status_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected result enc=%0b dirs=%0d gaps=%0d rej=%0b", $time,
                 out_if.enclosed, out_if.distinct_directions, out_if.gap_count,
                 out_if.rejected);
        errors++;
      end else begin
        w = pending_status.pop_front();
        if (w.enclosed !== out_if.enclosed || w.dirs !== out_if.distinct_directions ||
            w.gaps !== out_if.gap_count || w.rejected !== out_if.rejected) begin
          $display("%0t: expected enc=%0b dirs=%0d gaps=%0d rej=%0b, got %0b %0d %0d %0b",
                   $time, w.enclosed, w.dirs, w.gaps, w.rejected, out_if.enclosed,
                   out_if.distinct_directions, out_if.gap_count, out_if.rejected);
          errors++;
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("angular_hull_enclosure_tracker_core: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ahet_pkg.sv
rtl/ahet_in_if.sv
rtl/ahet_out_if.sv
rtl/ahet_cell.sv
rtl/ahet_chain.sv
rtl/angular_hull_enclosure_tracker_core.sv
rtl/ahet_chk.sv
tb/angular_hull_enclosure_tracker_core_tb.sv
